@@ design/hsa_pkg.sv @@
// Package for the handle slot allocator: action codes, default sizes, controller
// state type and the command/status bundles between controller and datapath.
// No dependencies.
package hsa_pkg;

    localparam int HSA_SLOTS_DEF   = 64;
    localparam int HSA_ID_BITS_DEF = 24;

    localparam int HSA_GROUP_W  = 8;
    localparam int HSA_HANDLE_W = 32;
    localparam int HSA_SLOTIX_W = 6;
    localparam int HSA_IN_W     = 40;
    localparam int HSA_OUT_W    = 40;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_LOOK,
        ST_CHECK,
        ST_EMIT
    } hsa_state_t;

    typedef struct packed {
        logic clr_step;     // clear one used bit during the pass after reset
        logic capture;      // take the incoming word into the request registers
        logic issue;        // issue the next probe read
        logic alloc_commit; // claim the probed slot
        logic alloc_fail;   // every slot was busy
        logic look_rd;      // read the slot addressed by the request handle
        logic check;        // compare the slot with the request handle
        logic nop_res;      // result for an unused action code
        logic emit;         // move the result into the output register
    } hsa_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] in_action;
        logic       probe_hit;
        logic       probe_fail;
        logic       out_free;
    } hsa_status_t;

endpackage

@@ design/hsa_ctrl.sv @@
// Controller state machine of the handle slot allocator.
// Depends on hsa_pkg; drives the datapath through hsa_cmd_t and reads hsa_status_t.
module hsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hsa_pkg::hsa_status_t st,
    output hsa_pkg::hsa_cmd_t    cmd
);
    import hsa_pkg::*;

    hsa_state_t state_reg;
    hsa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (st.in_action)
                        ACT_ALLOC:   state_next = ST_PROBE;
                        ACT_RELEASE: state_next = ST_LOOK;
                        ACT_LOOKUP:  state_next = ST_LOOK;
                        default:
                        begin
                            cmd.nop_res = 1'b1;
                            state_next  = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                if (st.probe_hit)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = ST_EMIT;
                end
                else if (st.probe_fail)
                begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_LOOK:
            begin
                cmd.look_rd = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A commit and a failure can never be decided in the same probe cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(st.probe_hit && st.probe_fail))
        else $error("probe hit and probe failure together");

    // The clearing pass ends before any word is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !cmd.capture)
        else $error("word captured during clearing pass");

    // Leaving the probe state always produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && state_next != ST_PROBE) |=> (state_reg == ST_EMIT))
        else $error("probe left without a result");
`endif

endmodule

@@ design/hsa_datapath.sv @@
// Datapath of the handle slot allocator: slot memories, serial counter, probe
// sequencer registers, group register and output register. Depends on hsa_pkg.
module hsa_datapath #(
    parameter int SLOTS   = hsa_pkg::HSA_SLOTS_DEF,
    parameter int ID_BITS = hsa_pkg::HSA_ID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hsa_pkg::hsa_cmd_t               cmd,
    output hsa_pkg::hsa_status_t            st,
    input  logic [hsa_pkg::HSA_IN_W-1:0]    in_data,
    input  logic                            cfg_valid,
    input  logic [hsa_pkg::HSA_GROUP_W-1:0] cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hsa_pkg::HSA_OUT_W-1:0]   out_data
);
    import hsa_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SLOTS);

    function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_BITS-1:0] id);
        logic [31:0] ext;
        ext = 32'(id);
        return ext[SLOT_W-1:0] & SLOT_MASK;
    endfunction

    logic                    used_mem [SLOTS];
    logic [HSA_HANDLE_W-1:0] handle_mem [SLOTS];

    logic [HSA_GROUP_W-1:0]  group_reg;
    logic [ID_BITS-1:0]      serial_reg;
    logic [ID_BITS-1:0]      id_issue_reg;
    logic [ID_BITS-1:0]      rd_id_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    pend_reg;
    logic [SLOT_W-1:0]       clr_cnt_reg;
    logic [1:0]              req_action_reg;
    logic [HSA_HANDLE_W-1:0] req_handle_reg;
    logic                    used_q;
    logic [HSA_HANDLE_W-1:0] handle_q;

    logic                    res_ok_reg;
    logic [HSA_HANDLE_W-1:0] res_handle_reg;
    logic [HSA_SLOTIX_W-1:0] res_slot_reg;
    logic                    out_valid_reg;
    logic                    out_ok_reg;
    logic [HSA_HANDLE_W-1:0] out_handle_reg;
    logic [HSA_SLOTIX_W-1:0] out_slot_reg;

    logic [SLOT_W-1:0]       rd_addr;
    logic [SLOT_W-1:0]       probe_slot;
    logic [SLOT_W-1:0]       look_slot;
    logic [HSA_HANDLE_W-1:0] group_bits;
    logic [HSA_HANDLE_W-1:0] alloc_handle;
    logic                    look_hit;
    logic                    used_we;
    logic [SLOT_W-1:0]       used_waddr;
    logic                    used_wdata;
    logic                    can_issue;

    assign group_bits   = HSA_HANDLE_W'(group_reg) << ID_BITS;
    assign probe_slot   = slot_of(rd_id_reg);
    assign look_slot    = slot_of(req_handle_reg[ID_BITS-1:0]);
    assign alloc_handle = HSA_HANDLE_W'(rd_id_reg) | group_bits;
    assign rd_addr      = cmd.look_rd ? look_slot : slot_of(id_issue_reg);
    assign look_hit     = used_q && (handle_q == req_handle_reg);
    assign can_issue    = cnt_reg != CNT_FULL;

    assign st.clr_last   = clr_cnt_reg == SLOT_LAST;
    assign st.in_action  = in_data[1:0];
    assign st.probe_hit  = pend_reg && !used_q;
    assign st.probe_fail = pend_reg && used_q && (cnt_reg == CNT_FULL);
    assign st.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        used_we    = 1'b0;
        used_waddr = clr_cnt_reg;
        used_wdata = 1'b0;
        if (cmd.clr_step)
        begin
            used_we = 1'b1;
        end
        else if (cmd.alloc_commit)
        begin
            used_we    = 1'b1;
            used_waddr = probe_slot;
            used_wdata = 1'b1;
        end
        else if (cmd.check && look_hit && req_action_reg == ACT_RELEASE)
        begin
            used_we    = 1'b1;
            used_waddr = look_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        if (cmd.alloc_commit)
        begin
            handle_mem[probe_slot] <= alloc_handle;
        end
        used_q   <= used_mem[rd_addr];
        handle_q <= handle_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg     <= '0;
            serial_reg    <= ID_BITS'(1);
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                group_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (cmd.capture)
            begin
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.issue)
            begin
                pend_reg <= can_issue;
                if (can_issue)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.alloc_commit)
            begin
                serial_reg <= rd_id_reg + ID_BITS'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_action_reg <= in_data[1:0];
            req_handle_reg <= in_data[33:2];
            id_issue_reg   <= serial_reg;
        end
        else if (cmd.issue && can_issue)
        begin
            rd_id_reg    <= id_issue_reg;
            id_issue_reg <= id_issue_reg + ID_BITS'(1);
        end
        if (cmd.alloc_commit)
        begin
            res_ok_reg     <= 1'b1;
            res_handle_reg <= alloc_handle;
            res_slot_reg   <= HSA_SLOTIX_W'(probe_slot);
        end
        else if (cmd.check)
        begin
            res_ok_reg     <= look_hit;
            res_handle_reg <= look_hit ? req_handle_reg : '0;
            res_slot_reg   <= HSA_SLOTIX_W'(look_slot);
        end
        else if (cmd.alloc_fail || cmd.nop_res)
        begin
            res_ok_reg     <= 1'b0;
            res_handle_reg <= '0;
            res_slot_reg   <= '0;
        end
        if (cmd.emit)
        begin
            out_ok_reg     <= res_ok_reg;
            out_handle_reg <= res_handle_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {1'b0, out_slot_reg, out_handle_reg, out_ok_reg};

`ifndef SYNTHESIS
    // The probe never issues more reads than there are slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("probe counter ran past the slot count");

    // A claimed slot moves the serial to one past the id just handed out.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |=> (serial_reg == $past(rd_id_reg) + ID_BITS'(1)))
        else $error("serial not advanced after allocation");

    // A failed word never carries a handle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_handle_reg == '0))
        else $error("failed result with nonzero handle");

    // A successful word names the slot addressed by its own handle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ok_reg) |->
            (out_slot_reg == HSA_SLOTIX_W'(slot_of(out_handle_reg[ID_BITS-1:0]))))
        else $error("result slot does not match handle");
`endif

endmodule

@@ design/handle_slot_allocator.sv @@
// Top level of the handle slot allocator: stream ports, configuration port,
// controller and datapath. Depends on hsa_pkg, hsa_ctrl and hsa_datapath.
//
//   port group   | direction | content
//   s_t*         | in        | request word: action, handle
//   m_t*         | out       | result word: ok, handle_out, slot_index
//   cfg_*        | in        | server_group register write
//
// Allocation probes slots in turn: the probe reads one slot per cycle
// from the single read port of the slot memory, pipelined against the check.
// Release and lookup do one slot read, then one compare.
// After reset a clearing pass resets the used bits; no request
// is accepted until it ends, while configuration writes are taken at any time.
// A finished word waits in the output register while the next request runs.
module handle_slot_allocator #(
    parameter int SLOTS   = hsa_pkg::HSA_SLOTS_DEF,
    parameter int ID_BITS = hsa_pkg::HSA_ID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] action, [33:2] handle, [39:34] zero
    input  logic [hsa_pkg::HSA_IN_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] ok, [32:1] handle_out, [38:33] slot_index, [39] zero
    output logic [hsa_pkg::HSA_OUT_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hsa_pkg::HSA_GROUP_W-1:0] cfg_data
);
    import hsa_pkg::*;

    hsa_cmd_t    cmd;
    hsa_status_t st;

    assign cfg_ready = 1'b1;

    hsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    hsa_datapath #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

@@ tb/handle_slot_allocator_tb.sv @@
// Self-checking testbench for handle_slot_allocator: directed table, then random phases
// under changing server groups; replies checked against the table or an in-bench allocator model.
// Depends on hsa_pkg and the handle_slot_allocator RTL.
module handle_slot_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsa_pkg::*;

    localparam int SLOT_COUNT   = HSA_SLOTS_DEF;
    localparam int ID_W         = HSA_ID_BITS_DEF;
    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 140;
    localparam int STALL_CYCLES = 400;
    // Longest quiet stretch of a correct run is the long receiver stall plus a full probe.
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic        ok;
        logic [31:0] handle;
        logic [5:0]  slot;
    } reply_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] handle;
        logic        known;
        reply_t      reply;
    } dir_row_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [HSA_IN_W-1:0]     s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [HSA_OUT_W-1:0]    m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [HSA_GROUP_W-1:0]  cfg_data  = '0;

    // Allocator state as the block should hold it.
    logic                    slot_busy  [SLOT_COUNT];
    logic [31:0]             slot_owner [SLOT_COUNT];
    logic [ID_W-1:0]         serial_next = ID_W'(1);
    logic [7:0]              group_reg   = '0;

    reply_t                  pending_replies [$];
    int                      mismatches  = 0;
    int                      quiet       = 0;
    int                      tx_idle_pct = 0;
    int                      rx_idle_pct = 0;
    int                      hold_left   = 0;
    logic                    hold_req    = 1'b0;

    // Rows with known set carry a reply that follows directly from the reset state.
    dir_row_t dir_rows [21] = '{
        '{ACT_LOOKUP,  32'h0000_0001, 1'b1, '{1'b0, 32'h0000_0000, 6'd1}},
        '{ACT_ALLOC,   32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0001, 6'd1}},
        '{ACT_ALLOC,   32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0002, 6'd2}},
        '{ACT_LOOKUP,  32'h0000_0001, 1'b1, '{1'b1, 32'h0000_0001, 6'd1}},
        '{ACT_LOOKUP,  32'hFF00_0001, 1'b1, '{1'b0, 32'h0000_0000, 6'd1}},
        '{ACT_LOOKUP,  32'h0000_0041, 1'b1, '{1'b0, 32'h0000_0000, 6'd1}},
        '{ACT_RELEASE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 6'd63}},
        '{ACT_RELEASE, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
        '{ACT_RELEASE, 32'h0000_0001, 1'b1, '{1'b1, 32'h0000_0001, 6'd1}},
        '{ACT_RELEASE, 32'h0000_0001, 1'b1, '{1'b0, 32'h0000_0000, 6'd1}},
        '{ACT_LOOKUP,  32'h0000_0001, 1'b1, '{1'b0, 32'h0000_0000, 6'd1}},
        '{ACT_NOP,     32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
        '{ACT_NOP,     32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
        '{ACT_ALLOC,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0003, 6'd3}},
        '{ACT_LOOKUP,  32'h00FF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 6'd63}},
        '{ACT_ALLOC,   32'h0000_0000, 1'b0, '0},
        '{ACT_ALLOC,   32'h0000_0000, 1'b0, '0},
        '{ACT_LOOKUP,  32'h0000_0002, 1'b1, '{1'b1, 32'h0000_0002, 6'd2}},
        '{ACT_RELEASE, 32'h0000_0002, 1'b1, '{1'b1, 32'h0000_0002, 6'd2}},
        '{ACT_ALLOC,   32'h0000_0000, 1'b0, '0},
        '{ACT_LOOKUP,  32'h0000_0006, 1'b0, '0}
    };

    handle_slot_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Applies one request to the allocator state and returns the reply it must produce.
    function automatic reply_t apply_request(input logic [1:0] act, input logic [31:0] h);
        reply_t          r;
        logic [ID_W-1:0] id;
        logic [5:0]      s;
        r = '0;
        if (act == ACT_ALLOC)
        begin
            for (int i = 0; i < SLOT_COUNT && !r.ok; i++)
            begin
                id = serial_next + ID_W'(i);
                s = id[5:0];
                if (!slot_busy[s])
                begin
                    slot_busy[s] = 1'b1;
                    slot_owner[s] = {group_reg, id};
                    serial_next = id + ID_W'(1);
                    r.ok = 1'b1;
                    r.handle = {group_reg, id};
                    r.slot = s;
                end
            end
        end
        else if (act == ACT_RELEASE || act == ACT_LOOKUP)
        begin
            s = h[5:0];
            r.slot = s;
            if (slot_busy[s] && slot_owner[s] == h)
            begin
                r.ok = 1'b1;
                r.handle = h;
                if (act == ACT_RELEASE)
                    slot_busy[s] = 1'b0;
            end
        end
        return r;
    endfunction

    // Mostly live handles, some with one bit flipped, the rest random or in the current group.
    function automatic logic [31:0] pick_handle();
        logic [31:0] h;
        int          roll;
        int          start;
        logic [5:0]  ix;
        logic [4:0]  flip;
        logic        found;
        roll = $urandom_range(99);
        h = $urandom;
        found = 1'b0;
        if (roll < 70)
        begin
            start = $urandom_range(SLOT_COUNT - 1);
            for (int k = 0; k < SLOT_COUNT && !found; k++)
            begin
                ix = 6'((start + k) % SLOT_COUNT);
                if (slot_busy[ix])
                begin
                    h = slot_owner[ix];
                    found = 1'b1;
                end
            end
            if (found && $urandom_range(4) == 0)
            begin
                flip = 5'($urandom_range(31));
                h[flip] = ~h[flip];
            end
        end
        else if (roll < 85)
        begin
            h[31:24] = group_reg;
        end
        return h;
    endfunction

    task automatic send_request(input logic [1:0] act, input logic [31:0] h,
                                input logic known, input reply_t typed);
        reply_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(HSA_IN_W - 34){1'b0}}, h, act};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_request(act, h);
        pending_replies.push_back(known ? typed : predicted);
    endtask

    // Checking at the falling edge keeps the test clear of the reply monitor at the rising one.
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_group(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        group_reg = value;
    endtask

    initial
    begin
        int         roll;
        int         alloc_pct;
        logic [1:0] act;
        logic [7:0] grp;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            slot_busy[k] = 1'b0;
            slot_owner[k] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct <= 11;
        rx_idle_pct <= 79;

        foreach (dir_rows[k])
            send_request(dir_rows[k].act, dir_rows[k].handle, dir_rows[k].known,
                         dir_rows[k].reply);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_replies();
            case (p)
                0, 6:    grp = 8'hFF;
                1, 7:    grp = 8'h00;
                3:       grp = 8'h80;
                4:       grp = 8'h01;
                default: grp = 8'($urandom);
            endcase
            write_group(grp);
            if (p < 3)
            begin
                tx_idle_pct <= 11;
                rx_idle_pct <= 79;
            end
            else if (p < 6)
            begin
                tx_idle_pct <= 79;
                rx_idle_pct <= 11;
            end
            else
            begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            // Even phases are allocation-heavy and fill the table; odd ones send more releases and lookups.
            alloc_pct = (p % 2 == 0) ? 85 : 35;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ((p == 1 || p == 6) && n == 20)
                    hold_req <= 1'b1;
                roll = $urandom_range(99);
                if (roll < alloc_pct)
                    act = ACT_ALLOC;
                else if (roll < alloc_pct + (100 - alloc_pct) / 2)
                    act = ACT_RELEASE;
                else if (roll < 96)
                    act = ACT_LOOKUP;
                else
                    act = ACT_NOP;
                send_request(act, pick_handle(), 1'b0, '0);
            end
        end

        wait_for_replies();
        repeat (SLOT_COUNT + 8) @(posedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold-off when the sender asks for one.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req <= 1'b0;
            hold_left = STALL_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (m_tvalid && m_tready)
        begin
            got.ok = m_tdata[0];
            got.handle = m_tdata[32:1];
            got.slot = m_tdata[38:33];
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: reply word %h arrived with nothing outstanding",
                             $realtime, m_tdata);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.ok !== want.ok || got.handle !== want.handle
                        || got.slot !== want.slot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: reply ok/handle/slot got %b/%h/%0d, want %b/%h/%0d",
                                 $realtime, got.ok, got.handle, got.slot,
                                 want.ok, want.handle, want.slot);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

@@ sim.f @@
design/hsa_pkg.sv
design/hsa_ctrl.sv
design/hsa_datapath.sv
design/handle_slot_allocator.sv
tb/handle_slot_allocator_tb.sv
